// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/mps_pkg.sv =====
package mps_pkg;
	localparam int BLOB_COUNT_DEF = 6;
	localparam int MAX_DIM = 64;

	localparam int POS_W  = 10;
	localparam int RAD_W  = 3;
	localparam int HEAT_W = 8;
	localparam int PIX_W  = 6;
	localparam int CLR_W  = 8;
	localparam int BIDX_W = 3;
	localparam int AB_W   = 3;
	localparam int BR_W   = 8;
	localparam int FW_W   = 7;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 8;

	localparam int INFL_W = 8;
	localparam int DX_W   = 13;
	localparam int DSQ_W  = 24;
	localparam int NUM_W  = 22;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	localparam logic [CIDX_W-1:0] CFG_ACTIVE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_BRIGHT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GEOM, ST_SQ, ST_DLOAD, ST_DSTEP, ST_ACC, ST_HLOAD,
		ST_HDIV, ST_SCALE, ST_VAL, ST_PAL, ST_FIN
	} state_t;

	typedef struct packed {
		logic       geom;
		logic       sq;
		logic       dload;
		logic       dstep;
		logic [2:0] bitk;
		logic       acc;
	} cell_ctrl_t;

	// floor(x/255) for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [24:0] t;
		t = (25'(x) + 25'd1) * 25'd257;
		return t[23:16];
	endfunction
endpackage

// ===== sv/mps_if.sv =====
interface mps_item_if;
	import mps_pkg::*;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [BIDX_W-1:0] blob_index;
	logic [POS_W-1:0]  blob_pos_x;
	logic [POS_W-1:0]  blob_pos_y;
	logic [RAD_W-1:0]  blob_size;
	logic [HEAT_W-1:0] blob_warmth;
	logic [PIX_W-1:0]  pixel_col;
	logic [PIX_W-1:0]  pixel_row;
	modport source (output valid, opcode, blob_index, blob_pos_x, blob_pos_y, blob_size,
		blob_warmth, pixel_col, pixel_row, input ready);
	modport sink (input valid, opcode, blob_index, blob_pos_x, blob_pos_y, blob_size,
		blob_warmth, pixel_col, pixel_row, output ready);
endinterface

interface mps_result_if;
	import mps_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_col;
	logic [PIX_W-1:0] out_row;
	logic [CLR_W-1:0] red;
	logic [CLR_W-1:0] green;
	logic [CLR_W-1:0] blue;
	modport source (output valid, out_col, out_row, red, green, blue, input ready);
	modport sink (input valid, out_col, out_row, red, green, blue, output ready);
endinterface

interface mps_cfg_if;
	import mps_pkg::*;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mps_cell.sv =====
module mps_cell #(
	parameter int SUM_W  = 11,
	parameter int HSUM_W = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [mps_pkg::POS_W-1:0]  wr_x,
	input  logic [mps_pkg::POS_W-1:0]  wr_y,
	input  logic [mps_pkg::RAD_W-1:0]  wr_rad,
	input  logic [mps_pkg::HEAT_W-1:0] wr_heat,
	input  logic [mps_pkg::PIX_W-1:0]  pix_col,
	input  logic [mps_pkg::PIX_W-1:0]  pix_row,
	input  logic [9:0]                 half16,
	input  logic [10:0]                full16,
	input  logic                       enable,
	input  mps_pkg::cell_ctrl_t        ctrl,
	input  logic [SUM_W-1:0]           sum_in,
	input  logic [HSUM_W-1:0]          hsum_in,
	output logic [SUM_W-1:0]           sum_out,
	output logic [HSUM_W-1:0]          hsum_out
);
	import mps_pkg::*;

	logic [POS_W-1:0]  cx_q, cy_q;
	logic [RAD_W-1:0]  rad_q;
	logic [HEAT_W-1:0] heat_q;

	logic signed [DX_W-1:0] half_s, full_s, dx0, dx1, dx2, dy0;
	logic signed [DX_W-1:0] dx_q, dy_q;
	logic signed [2*DX_W-1:0] dxx, dyy;
	logic [DSQ_W-1:0] dsum, dsq_q;
	logic [5:0] rsq;
	logic [NUM_W-1:0] num, rem_q;
	logic [31:0] shifted;
	logic sat_q;
	logic [INFL_W-1:0] quo_q, infl;
	logic [SUM_W-1:0] sum_q;
	logic [HSUM_W-1:0] hsum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			rad_q  <= '0;
			heat_q <= '0;
		end else if (wr) begin
			cx_q   <= wr_x;
			cy_q   <= wr_y;
			rad_q  <= wr_rad;
			heat_q <= wr_heat;
		end
	end

	always_comb begin
		half_s = $signed({3'b000, half16});
		full_s = $signed({2'b00, full16});
		dx0 = $signed({3'b000, pix_col, 4'b0000}) - $signed({3'b000, cx_q});
		dy0 = $signed({3'b000, pix_row, 4'b0000}) - $signed({3'b000, cy_q});
		dx1 = (dx0 > half_s) ? dx0 - full_s : dx0;
		dx2 = (dx1 < -half_s) ? dx1 + full_s : dx1;
		dxx = dx_q * dx_q;
		dyy = dy_q * dy_q;
		dsum = dxx[DSQ_W-1:0] + dyy[DSQ_W-1:0];
		rsq = 6'(rad_q) * 6'(rad_q);
		num = {rsq, 16'h0000};
		shifted = {8'h00, dsq_q} << ctrl.bitk;
		infl = !enable ? '0 : (sat_q ? 8'd255 : quo_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.geom) begin
			dx_q <= dx2;
			dy_q <= dy0;
		end
		if (ctrl.sq)
			dsq_q <= (dsum == '0) ? DSQ_W'(1) : dsum;
		if (ctrl.dload) begin
			rem_q <= num;
			sat_q <= {10'b0, num} >= {dsq_q, 8'h00};
			quo_q <= '0;
		end else if (ctrl.dstep) begin
			if ({10'b0, rem_q} >= shifted) begin
				rem_q <= rem_q - shifted[NUM_W-1:0];
				quo_q[ctrl.bitk] <= 1'b1;
			end
		end
		if (ctrl.acc) begin
			sum_q  <= sum_in + SUM_W'(infl);
			hsum_q <= hsum_in + HSUM_W'(16'(heat_q) * 16'(infl));
		end
	end

	assign sum_out  = sum_q;
	assign hsum_out = hsum_q;
endmodule

// ===== sv/metaball_pixel_shader_unit.sv =====
// Shade transaction: the result is registered after the 8-step influence division in
// every cell, the carry of the sums along the cell row (one cell per cycle) and the
// 8-step mean-heat division; ST_FIN waits while an older result is not taken. The next
// transaction is taken as the result turns valid. A blob write is stored when accepted.
// Reset (arst_n low, asynchronous): blob table cleared, registers to 4 / 200 / 64, idle.
`include "assert_macros.svh"

module metaball_pixel_shader_unit #(
	parameter int MAX_BLOB_COUNT = mps_pkg::BLOB_COUNT_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mps_item_if.sink     item,
	mps_result_if.source result,
	mps_cfg_if.sink      cfg
);
	import mps_pkg::*;

	localparam int SUM_W  = INFL_W + $clog2(MAX_BLOB_COUNT);
	localparam int HSUM_W = 2 * INFL_W + $clog2(MAX_BLOB_COUNT);
	localparam int CNT_W  = ($clog2(MAX_BLOB_COUNT) > 3) ? $clog2(MAX_BLOB_COUNT) : 3;
	localparam int BC_W   = $clog2(MAX_BLOB_COUNT + 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	cell_ctrl_t ctrl;

	logic [AB_W-1:0] ab_q;
	logic [BR_W-1:0] bright_q;
	logic [FW_W-1:0] fw_q;
	logic [BC_W-1:0] count;
	logic [FW_W-1:0] w;

	logic [PIX_W-1:0] col_q, row_q;
	logic item_acc, shade_acc, write_acc;

	logic [SUM_W-1:0]  sum_chain  [0:MAX_BLOB_COUNT];
	logic [HSUM_W-1:0] hsum_chain [0:MAX_BLOB_COUNT];

	logic [HSUM_W-1:0] hrem_q, hsh;
	logic [SUM_W-1:0]  hden_q;
	logic [7:0]        hquo_q;

	logic [7:0]  field_q, heat_q, val_q, fld;
	logic [15:0] prod_q;
	logic [1:0]  dim_q;
	logic        glow_q;
	logic [7:0]  r0, g0, b0, s;
	logic [9:0]  t3;
	logic [15:0] s171;
	logic [15:0] rp_q, gp_q, bp_q;

	logic out_valid_q;
	logic [PIX_W-1:0] ocol_q, orow_q;
	logic [CLR_W-1:0] red_q, green_q, blue_q;
	logic fin_load;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_q     <= AB_W'(4);
			bright_q <= BR_W'(200);
			fw_q     <= FW_W'(64);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_ACTIVE: ab_q     <= cfg.data[AB_W-1:0];
				CFG_BRIGHT: bright_q <= cfg.data[BR_W-1:0];
				CFG_WIDTH:  fw_q     <= cfg.data[FW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ab_q < AB_W'(2))
			count = BC_W'(2);
		else if (32'(ab_q) > MAX_BLOB_COUNT)
			count = BC_W'(MAX_BLOB_COUNT);
		else
			count = BC_W'(ab_q);
		if (fw_q == '0)
			w = FW_W'(1);
		else if (32'(fw_q) > MAX_DIM)
			w = FW_W'(MAX_DIM);
		else
			w = fw_q;
	end

	// input side
	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign shade_acc  = item_acc && (item.opcode == OP_SHADE);
	assign write_acc  = item_acc && (item.opcode == OP_WRITE);

	always_ff @(posedge clk) begin
		if (shade_acc) begin
			col_q <= item.pixel_col;
			row_q <= item.pixel_row;
		end
	end

	// cell row
	assign sum_chain[0]  = '0;
	assign hsum_chain[0] = '0;

	for (genvar i = 0; i < MAX_BLOB_COUNT; i++) begin : g_cell
		mps_cell #(
			.SUM_W  (SUM_W),
			.HSUM_W (HSUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (write_acc && (32'(item.blob_index) == i)),
			.wr_x     (item.blob_pos_x),
			.wr_y     (item.blob_pos_y),
			.wr_rad   (item.blob_size),
			.wr_heat  (item.blob_warmth),
			.pix_col  (col_q),
			.pix_row  (row_q),
			.half16   ({w, 3'b000}),
			.full16   ({w, 4'b0000}),
			.enable   (BC_W'(i) < count),
			.ctrl     (ctrl),
			.sum_in   (sum_chain[i]),
			.hsum_in  (hsum_chain[i]),
			.sum_out  (sum_chain[i+1]),
			.hsum_out (hsum_chain[i+1])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (shade_acc) state_d = ST_GEOM;
			ST_GEOM:  state_d = ST_SQ;
			ST_SQ:    state_d = ST_DLOAD;
			ST_DLOAD: state_d = ST_DSTEP;
			ST_DSTEP: if (cnt_q == '0) state_d = ST_ACC;
			ST_ACC:   if (cnt_q == '0) state_d = ST_HLOAD;
			ST_HLOAD: state_d = ST_HDIV;
			ST_HDIV:  if (cnt_q == '0) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_VAL;
			ST_VAL:   state_d = ST_PAL;
			ST_PAL:   state_d = ST_FIN;
			ST_FIN:   if (fin_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.geom  = (state_q == ST_GEOM);
		ctrl.sq    = (state_q == ST_SQ);
		ctrl.dload = (state_q == ST_DLOAD);
		ctrl.dstep = (state_q == ST_DSTEP);
		ctrl.bitk  = cnt_q[2:0];
		ctrl.acc   = (state_q == ST_ACC);
		fin_load   = (state_q == ST_FIN) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else begin
			case (state_q)
				ST_DLOAD: cnt_q <= CNT_W'(7);
				ST_DSTEP: cnt_q <= (cnt_q == '0) ? CNT_W'(MAX_BLOB_COUNT - 1) : cnt_q - 1'b1;
				ST_ACC:   cnt_q <= cnt_q - 1'b1;
				ST_HLOAD: cnt_q <= CNT_W'(7);
				ST_HDIV:  cnt_q <= cnt_q - 1'b1;
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	// mean heat, then colour
	always_comb begin
		hsh = HSUM_W'(hden_q) << cnt_q[2:0];
		fld = (sum_chain[MAX_BLOB_COUNT] > SUM_W'(255)) ? 8'd255
			: sum_chain[MAX_BLOB_COUNT][7:0];
		s    = heat_q - 8'd170;
		t3   = 10'(heat_q) * 10'd3;
		s171 = 16'(s) * 16'd171;
		if (heat_q < 8'd85) begin
			r0 = t3[7:0];
			g0 = 8'd0;
			b0 = 8'd0;
		end else if (heat_q < 8'd170) begin
			r0 = 8'd255;
			g0 = {heat_q[6:0] - 7'd85, 1'b0};
			b0 = 8'd0;
		end else begin
			r0 = 8'd255;
			g0 = 8'd170 + s;
			b0 = {1'b0, s171[15:9]};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_HLOAD: begin
				hrem_q <= hsum_chain[MAX_BLOB_COUNT];
				hden_q <= sum_chain[MAX_BLOB_COUNT];
				hquo_q <= '0;
			end
			ST_HDIV: begin
				if (hrem_q >= hsh) begin
					hrem_q <= hrem_q - hsh;
					hquo_q[cnt_q[2:0]] <= 1'b1;
				end
			end
			ST_SCALE: begin
				field_q <= fld;
				prod_q  <= 16'(fld) * 16'(bright_q);
			end
			ST_VAL: begin
				val_q  <= div255(prod_q);
				heat_q <= (hden_q == '0) ? 8'd180 : hquo_q;
				glow_q <= field_q > 8'd25;
				if (prod_q >= 16'd5100)
					dim_q <= 2'd2;
				else if (prod_q >= 16'd2550)
					dim_q <= 2'd1;
				else
					dim_q <= 2'd0;
			end
			ST_PAL: begin
				rp_q <= 16'(r0) * 16'(val_q);
				gp_q <= 16'(g0) * 16'(val_q);
				bp_q <= 16'(b0) * 16'(val_q);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			ocol_q  <= col_q;
			orow_q  <= row_q;
			red_q   <= glow_q ? div255(rp_q) : {6'b0, dim_q};
			green_q <= glow_q ? div255(gp_q) : 8'd0;
			blue_q  <= glow_q ? div255(bp_q) : 8'd0;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.out_col = ocol_q;
	assign result.out_row = orow_q;
	assign result.red     = red_q;
	assign result.green   = green_q;
	assign result.blue    = blue_q;

	`ASSERT_NEXT(a_shade_starts, clk, arst_n, shade_acc, state_q == ST_GEOM)
	`ASSERT_NEXT(a_fin_holds, clk, arst_n, state_q == ST_FIN && out_valid_q && !result.ready, state_q == ST_FIN)
	`ASSERT_IMPLIES(a_green_le_red, clk, arst_n, result.valid, result.green <= result.red)
	`ASSERT_IMPLIES(a_blue_le_green, clk, arst_n, result.valid, result.blue <= result.green)
endmodule
